@@ rtl/core/bemsd_pkg.sv @@
// Shared types, widths, register codes and reset values of the binned error statistics block.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none
package bemsd_pkg;

   localparam int VAL_W  = 24;
   localparam int STEP_W = 23;
   localparam int CX_W   = 5;
   localparam int CY_W   = 6;
   localparam int COL_W  = 4;
   localparam int ROW_W  = 5;
   localparam int SD_W   = 23;
   localparam int SUM_W  = 48;
   localparam int SQ_W   = 64;
   localparam int CNT_W  = 24;
   localparam int ERR_W  = 25;
   localparam int NUM_W  = 28;
   localparam int DVD_W  = 64;
   localparam int DVS_W  = 24;
   localparam int ROOT_W = 32;
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam int DEF_MAX_COLS = 16;
   localparam int DEF_MAX_ROWS = 32;

   localparam logic signed [VAL_W-1:0] RST_MIN_X   = 24'sd0;
   localparam logic [STEP_W-1:0]       RST_STEP_X  = 23'd128;
   localparam logic [CX_W-1:0]         RST_COUNT_X = 5'd13;
   localparam logic signed [VAL_W-1:0] RST_MIN_Y   = 24'sd0;
   localparam logic [STEP_W-1:0]       RST_STEP_Y  = 23'd512;
   localparam logic [CY_W-1:0]         RST_COUNT_Y = 6'd26;
   localparam logic signed [VAL_W-1:0] RST_MIN_W2  = 24'sd0;
   localparam logic signed [VAL_W-1:0] RST_MAX_W2  = 24'sd256000;

   localparam logic MODE_ACCUM = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef enum logic [2:0] {
      CSR_MIN_X, CSR_STEP_X, CSR_COUNT_X, CSR_MIN_Y,
      CSR_STEP_Y, CSR_COUNT_Y, CSR_MIN_W2, CSR_MAX_W2
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_DIV_Y, ST_DIV_X, ST_READ, ST_UPDATE,
      ST_DIV_MEAN, ST_DIV_SQ, ST_SQUARE, ST_ROOT_CHK, ST_SQRT, ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [SQ_W-1:0]         sq;
      logic [CNT_W-1:0]        cnt;
   } entry_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic            start;
      logic [SQ_W-1:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage
`default_nettype wire

@@ rtl/core/bemsd_if.sv @@
// Valid/ready channel interfaces for the request and response beats.
// Depends on bemsd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface bemsd_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    mode;
   logic signed [bemsd_pkg::VAL_W-1:0]      estimate;
   logic signed [bemsd_pkg::VAL_W-1:0]      truth;
   logic signed [bemsd_pkg::VAL_W-1:0]      power_one;
   logic signed [bemsd_pkg::VAL_W-1:0]      power_two;
   logic signed [bemsd_pkg::VAL_W-1:0]      width_one;
   logic signed [bemsd_pkg::VAL_W-1:0]      width_two;
   logic [bemsd_pkg::COL_W-1:0]             read_col;
   logic [bemsd_pkg::ROW_W-1:0]             read_row;
   modport source (output valid, mode, estimate, truth, power_one, power_two, width_one,
                   width_two, read_col, read_row, input ready);
   modport sink (input valid, mode, estimate, truth, power_one, power_two, width_one,
                 width_two, read_col, read_row, output ready);
endinterface

interface bemsd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                accepted;
   logic [bemsd_pkg::CNT_W-1:0]         bin_count;
   logic signed [bemsd_pkg::VAL_W-1:0]  bin_mean;
   logic [bemsd_pkg::SD_W-1:0]          bin_sdev;
   modport source (output valid, accepted, bin_count, bin_mean, bin_sdev, input ready);
   modport sink (input valid, accepted, bin_count, bin_mean, bin_sdev, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bemsd_store.sv @@
// Bin statistics memory: one word per bin, one write and one registered read port.
// Depends on bemsd_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module bemsd_store #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AW-1:0]        waddr,
   input  wire bemsd_pkg::entry_type wdata,
   input  wire logic                 re,
   input  wire logic [AW-1:0]        raddr,
   output      bemsd_pkg::entry_type rdata
);
   import bemsd_pkg::*;

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ rtl/core/bemsd_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on bemsd_pkg for the request and response types.
`timescale 1ns / 1ps
`default_nettype none
module bemsd_div (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bemsd_pkg::div_req_type req,
   output      bemsd_pkg::div_rsp_type rsp
);
   import bemsd_pkg::*;

   localparam int CW = $clog2(DVD_W);

   logic             busy_ff, done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W-1:0] rem_ff, dvs_ff;
   logic [DVS_W:0]   shifted, diff;
   logic             take;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      take    = shifted >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CW'(DVD_W-1));
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(DVD_W-1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         dvs_ff <= req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DVD_W-2:0], take};
         rem_ff <= take ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule
`default_nettype wire

@@ rtl/core/bemsd_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle, floor result.
// Depends on bemsd_pkg for the request and response types.
`timescale 1ns / 1ps
`default_nettype none
module bemsd_sqrt (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bemsd_pkg::sqrt_req_type req,
   output      bemsd_pkg::sqrt_rsp_type rsp
);
   import bemsd_pkg::*;

   localparam int CW    = $clog2(ROOT_W);
   localparam int REM_W = ROOT_W + 2;

   logic              busy_ff, done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [SQ_W-1:0]   val_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W+1:0]  shifted, trial;
   logic              take;

   always_comb begin
      shifted = {rem_ff, val_ff[SQ_W-1:SQ_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      take    = shifted >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CW'(ROOT_W-1));
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(ROOT_W-1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         val_ff  <= req.value;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         val_ff  <= {val_ff[SQ_W-3:0], 2'b00};
         rem_ff  <= take ? REM_W'(shifted - trial) : REM_W'(shifted);
         root_ff <= {root_ff[ROOT_W-2:0], take};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule
`default_nettype wire

@@ rtl/core/binned_error_mean_sdev_matrix.sv @@
// Top level of the binned error statistics block: registers, control and datapath.
// Depends on bemsd_pkg, bemsd_if, bemsd_store, bemsd_div and bemsd_sqrt.
//
//   Port        Direction  Beat contents
//   req_chan    in         mode, estimate, truth, powers, widths, read_col, read_row
//   rsp_chan    out        accepted, bin_count, bin_mean, bin_sdev
//   APB (p*)    in/out     eight axis and width-window registers
//
// One item is worked at a time. An accumulate beat takes two index divisions and a
// read-modify-write; a read beat takes two divisions, a multiply and a root. All of the
// divisions go through the shared divider.
// After reset and after every axis register write, a clearing pass over all
// MAX_COLS*MAX_ROWS entries runs and no request beat is taken.
// A waiting response beat does not block the next request beat.
`timescale 1ns / 1ps
`default_nettype none
module binned_error_mean_sdev_matrix #(
   parameter int MAX_COLS = bemsd_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = bemsd_pkg::DEF_MAX_ROWS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   bemsd_req_if.sink                         req_chan,
   bemsd_rsp_if.source                       rsp_chan,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [bemsd_pkg::CSR_AW-1:0] paddr,
   input  wire logic [bemsd_pkg::CSR_DW-1:0] pwdata,
   output      logic [bemsd_pkg::CSR_DW-1:0] prdata,
   output      logic                         pready
);
   import bemsd_pkg::*;

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
   localparam int CW    = $clog2(MAX_COLS > 1 ? MAX_COLS : 2);
   localparam int RW    = $clog2(MAX_ROWS > 1 ? MAX_ROWS : 2);
   localparam int NCW   = $clog2(MAX_COLS + 1);
   localparam int NRW   = $clog2(MAX_ROWS + 1);

   // Configuration registers.
   logic signed [VAL_W-1:0] min_x_ff, min_y_ff, min_w2_ff, max_w2_ff;
   logic [STEP_W-1:0]       step_x_ff, step_y_ff;
   logic [CX_W-1:0]         count_x_ff;
   logic [CY_W-1:0]         count_y_ff;
   logic                    cfg_wr, axis_wr;
   csr_idx_type             csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = csr_idx_type'(paddr[4:2]);
   assign cfg_wr  = psel && penable && pwrite;
   assign axis_wr = cfg_wr && (csr_idx == CSR_MIN_X || csr_idx == CSR_STEP_X ||
                               csr_idx == CSR_COUNT_X || csr_idx == CSR_MIN_Y ||
                               csr_idx == CSR_STEP_Y || csr_idx == CSR_COUNT_Y);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff   <= RST_MIN_X;
         step_x_ff  <= RST_STEP_X;
         count_x_ff <= RST_COUNT_X;
         min_y_ff   <= RST_MIN_Y;
         step_y_ff  <= RST_STEP_Y;
         count_y_ff <= RST_COUNT_Y;
         min_w2_ff  <= RST_MIN_W2;
         max_w2_ff  <= RST_MAX_W2;
      end else if (cfg_wr) begin
         unique case (csr_idx)
            CSR_MIN_X:   min_x_ff   <= pwdata[VAL_W-1:0];
            CSR_STEP_X:  step_x_ff  <= pwdata[STEP_W-1:0];
            CSR_COUNT_X: count_x_ff <= pwdata[CX_W-1:0];
            CSR_MIN_Y:   min_y_ff   <= pwdata[VAL_W-1:0];
            CSR_STEP_Y:  step_y_ff  <= pwdata[STEP_W-1:0];
            CSR_COUNT_Y: count_y_ff <= pwdata[CY_W-1:0];
            CSR_MIN_W2:  min_w2_ff  <= pwdata[VAL_W-1:0];
            CSR_MAX_W2:  max_w2_ff  <= pwdata[VAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_MIN_X:   prdata = CSR_DW'(unsigned'(min_x_ff));
         CSR_STEP_X:  prdata = CSR_DW'(step_x_ff);
         CSR_COUNT_X: prdata = CSR_DW'(count_x_ff);
         CSR_MIN_Y:   prdata = CSR_DW'(unsigned'(min_y_ff));
         CSR_STEP_Y:  prdata = CSR_DW'(step_y_ff);
         CSR_COUNT_Y: prdata = CSR_DW'(count_y_ff);
         CSR_MIN_W2:  prdata = CSR_DW'(unsigned'(min_w2_ff));
         CSR_MAX_W2:  prdata = CSR_DW'(unsigned'(max_w2_ff));
         default:     prdata = '0;
      endcase
   end

   // Bins in use on each axis.
   logic [NCW-1:0] ncol;
   logic [NRW-1:0] nrow;
   logic           xok, yok;

   always_comb begin
      ncol = (32'(count_x_ff) > MAX_COLS) ? NCW'(MAX_COLS) : NCW'(count_x_ff);
      nrow = (32'(count_y_ff) > MAX_ROWS) ? NRW'(MAX_ROWS) : NRW'(count_y_ff);
      xok  = (step_x_ff != '0) && (ncol != '0);
      yok  = (step_y_ff != '0) && (nrow != '0);
   end

   // Control and datapath state.
   state_type               state_ff, state_in;
   logic [AW-1:0]           clr_ff;
   logic                    accept;
   logic                    mode_ff, win_ok_ff;
   logic signed [ERR_W-1:0] err_ff, dy_ff;
   logic signed [VAL_W-1:0] w1_ff;
   logic [COL_W-1:0]        rcol_ff;
   logic [ROW_W-1:0]        rrow_ff;
   logic [ERR_W-1:0]        abs_err;
   logic [2*ERR_W-1:0]      e2_ff;
   logic                    negx_ff, negy_ff;
   logic [NUM_W-1:0]        absx_ff;
   logic [RW-1:0]           row_ff;
   logic [CW-1:0]           col_ff;
   logic [AW-1:0]           addr;
   entry_type               ent_ff;
   logic [SUM_W-1:0]        mag_ff;
   logic [SQ_W-1:0]         q_ff, m2_ff;
   logic                    res_acc_ff;
   logic [CNT_W-1:0]        res_cnt_ff;
   logic signed [VAL_W-1:0] res_mean_ff;
   logic [SD_W-1:0]         res_sd_ff;
   logic                    rsp_valid_ff, rsp_acc_ff;
   logic [CNT_W-1:0]        rsp_cnt_ff;
   logic signed [VAL_W-1:0] rsp_mean_ff;
   logic [SD_W-1:0]         rsp_sd_ff;

   logic signed [NUM_W-1:0] difx, dify, numx, numy;
   logic [NUM_W-1:0]        magx, magy;
   logic                    x_hit, y_hit, rd_ok;
   logic [SUM_W:0]          sum_ext;
   logic [SQ_W:0]           sq_ext;
   entry_type               upd;
   logic [ROOT_W-1:0]       m_cap;
   logic signed [VAL_W-1:0] mean_sat;
   logic [SD_W-1:0]         sd_sat;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;
   logic         mem_we, mem_re;
   logic [AW-1:0] mem_waddr;
   entry_type    mem_wdata, mem_rdata;

   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      dify  = NUM_W'(dy_ff) - NUM_W'(min_y_ff);
      difx  = NUM_W'(w1_ff) - NUM_W'(min_x_ff);
      numy  = (dify <<< 1) + NUM_W'(step_y_ff);
      numx  = (difx <<< 1) + NUM_W'(step_x_ff);
      magy  = numy[NUM_W-1] ? NUM_W'(-numy) : NUM_W'(numy);
      magx  = numx[NUM_W-1] ? NUM_W'(-numx) : NUM_W'(numx);
      y_hit = negy_ff ? (div_rsp.quotient == '0) : (div_rsp.quotient < DVD_W'(nrow));
      x_hit = negx_ff ? (div_rsp.quotient == '0) : (div_rsp.quotient < DVD_W'(ncol));
      rd_ok = (32'(rcol_ff) < 32'(ncol)) && (32'(rrow_ff) < 32'(nrow));
      addr  = AW'(32'(row_ff) * MAX_COLS + 32'(col_ff));
      abs_err = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   end

   // Accumulate update with saturation on each field.
   always_comb begin
      sum_ext = {mem_rdata.sum[SUM_W-1], mem_rdata.sum} + (SUM_W+1)'(err_ff);
      sq_ext  = {1'b0, mem_rdata.sq} + (SQ_W+1)'(e2_ff);
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
         upd.sum = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         upd.sum = sum_ext[SUM_W-1:0];
      end
      upd.sq  = sq_ext[SQ_W] ? '1 : sq_ext[SQ_W-1:0];
      upd.cnt = (&mem_rdata.cnt) ? mem_rdata.cnt : mem_rdata.cnt + 1'b1;
   end

   // Read statistics: mean saturation, magnitude cap and root cap.
   always_comb begin
      m_cap   = (mag_ff > SUM_W'(32'hFFFF_FFFF)) ? '1 : mag_ff[ROOT_W-1:0];
      if (!ent_ff.sum[SUM_W-1]) begin
         mean_sat = (div_rsp.quotient > DVD_W'(24'h7F_FFFF)) ? 24'sh7F_FFFF
                                                             : div_rsp.quotient[VAL_W-1:0];
      end else begin
         mean_sat = (div_rsp.quotient > DVD_W'(24'h80_0000)) ? 24'sh80_0000
                                     : VAL_W'(24'd0 - div_rsp.quotient[VAL_W-1:0]);
      end
      sd_sat = (sqrt_rsp.root > ROOT_W'(23'h7F_FFFF)) ? '1 : sqrt_rsp.root[SD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      req_chan.ready    = 1'b0;
      div_req           = '0;
      sqrt_req          = '0;
      mem_we            = 1'b0;
      mem_waddr         = clr_ff;
      mem_wdata         = '0;
      mem_re            = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_ff == AW'(DEPTH-1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (mode_ff == MODE_READ) begin
               state_in = rd_ok ? ST_READ : ST_DONE;
            end else if (win_ok_ff && xok && yok) begin
               div_req.start    = 1'b1;
               div_req.dividend = DVD_W'(magy);
               div_req.divisor  = {step_y_ff, 1'b0};
               state_in         = ST_DIV_Y;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIV_Y: begin
            if (div_rsp.done) begin
               if (y_hit) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DVD_W'(absx_ff);
                  div_req.divisor  = {step_x_ff, 1'b0};
                  state_in         = ST_DIV_X;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV_X: begin
            if (div_rsp.done) begin
               state_in = x_hit ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (mode_ff == MODE_ACCUM) begin
               mem_we    = 1'b1;
               mem_waddr = addr;
               mem_wdata = upd;
               state_in  = ST_DONE;
            end else if (mem_rdata.cnt == '0) begin
               state_in = ST_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DVD_W'(unsigned'(mem_rdata.sum[SUM_W-1]
                                                   ? SUM_W'(-mem_rdata.sum)
                                                   : SUM_W'(mem_rdata.sum)));
               div_req.divisor  = mem_rdata.cnt;
               state_in         = ST_DIV_MEAN;
            end
         end
         ST_DIV_MEAN: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = ent_ff.sq;
               div_req.divisor  = ent_ff.cnt;
               state_in         = ST_DIV_SQ;
            end
         end
         ST_DIV_SQ: begin
            if (div_rsp.done) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_ROOT_CHK;
         end
         ST_ROOT_CHK: begin
            if (q_ff > m2_ff) begin
               sqrt_req.start = 1'b1;
               sqrt_req.value = q_ff - m2_ff;
               state_in       = ST_SQRT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SQRT: begin
            if (sqrt_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (axis_wr) begin
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (axis_wr) begin
            clr_ff <= '0;
         end else if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_chan.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      e2_ff <= abs_err * abs_err;
      if (accept) begin
         mode_ff     <= req_chan.mode;
         err_ff      <= ERR_W'(req_chan.estimate) - ERR_W'(req_chan.truth);
         dy_ff       <= ERR_W'(req_chan.power_one) - ERR_W'(req_chan.power_two);
         w1_ff       <= req_chan.width_one;
         win_ok_ff   <= (req_chan.width_two >= min_w2_ff) && (req_chan.width_two < max_w2_ff);
         rcol_ff     <= req_chan.read_col;
         rrow_ff     <= req_chan.read_row;
         res_acc_ff  <= 1'b0;
         res_cnt_ff  <= '0;
         res_mean_ff <= '0;
         res_sd_ff   <= '0;
      end
      if (state_ff == ST_CHECK) begin
         negy_ff <= numy[NUM_W-1];
         negx_ff <= numx[NUM_W-1];
         absx_ff <= magx;
         row_ff  <= RW'(rrow_ff);
         col_ff  <= CW'(rcol_ff);
      end
      if (state_ff == ST_DIV_Y && div_rsp.done) begin
         row_ff <= negy_ff ? '0 : div_rsp.quotient[RW-1:0];
      end
      if (state_ff == ST_DIV_X && div_rsp.done) begin
         col_ff <= negx_ff ? '0 : div_rsp.quotient[CW-1:0];
      end
      if (state_ff == ST_UPDATE) begin
         ent_ff     <= mem_rdata;
         res_acc_ff <= 1'b1;
         if (mode_ff == MODE_READ) begin
            res_cnt_ff <= mem_rdata.cnt;
         end
      end
      if (state_ff == ST_DIV_MEAN && div_rsp.done) begin
         mag_ff      <= div_rsp.quotient[SUM_W-1:0];
         res_mean_ff <= mean_sat;
      end
      if (state_ff == ST_DIV_SQ && div_rsp.done) begin
         q_ff <= div_rsp.quotient;
      end
      if (state_ff == ST_SQUARE) begin
         m2_ff <= m_cap * m_cap;
      end
      if (state_ff == ST_SQRT && sqrt_rsp.done) begin
         res_sd_ff <= sd_sat;
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_acc_ff  <= res_acc_ff;
         rsp_cnt_ff  <= res_cnt_ff;
         rsp_mean_ff <= res_mean_ff;
         rsp_sd_ff   <= res_sd_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.accepted  = rsp_acc_ff;
   assign rsp_chan.bin_count = rsp_cnt_ff;
   assign rsp_chan.bin_mean  = rsp_mean_ff;
   assign rsp_chan.bin_sdev  = rsp_sd_ff;

   bemsd_store #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_store (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .re   (mem_re),
      .raddr(addr),
      .rdata(mem_rdata)
   );

   bemsd_div u_div (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   bemsd_sqrt u_sqrt (
      .clock(clock),
      .reset(reset),
      .req  (sqrt_req),
      .rsp  (sqrt_rsp)
   );

   // The store is written only by the clearing pass or the accumulate update.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_UPDATE))
      else $error("store written outside clear or update");

   // The divider is never restarted while it still works on an operand.
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // An accepted request beat is checked in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !axis_wr) |=> state_ff == ST_CHECK)
      else $error("accepted beat not checked");

   // The clearing pass steps through the store one entry a cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && !axis_wr) |=> clr_ff == $past(clr_ff) + 1'b1)
      else $error("clearing pass skipped an entry");

endmodule
`default_nettype wire
